>>> rtl/mavg3_pkg.sv
package mavg3_pkg;

	// Width of the window length register.
	localparam int WL_BITS = 9;

	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Kind of work an item needs once it reaches the back.
	typedef enum logic {
		OP_PRIME,   // fill a history slot, no result
		OP_STEADY   // replace the oldest sample, give the window means
	} mavg3_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_UPDATE,
		BK_DIV
	} mavg3_bk_state_t;

endpackage

>>> rtl/mavg3_ifs.sv
interface mavg3_smp_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_x;
	logic signed [SAMPLE_BITS-1:0] sample_y;
	logic signed [SAMPLE_BITS-1:0] sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface mavg3_mean_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mean_x;
	logic signed [SAMPLE_BITS-1:0] mean_y;
	logic signed [SAMPLE_BITS-1:0] mean_z;

	modport source (output valid, output mean_x, output mean_y, output mean_z,
		input ready);
	modport sink (input valid, input mean_x, input mean_y, input mean_z,
		output ready);
endinterface

interface mavg3_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mavg3_pkg::WL_BITS-1:0]   window_length;

	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

>>> rtl/mavg3_queue.sv
module mavg3_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);
	localparam int PTR_W = $clog2(mavg3_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mavg3_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [mavg3_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(mavg3_pkg::QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

>>> rtl/mavg3_front.sv
module mavg3_front #(
	parameter int HISTORY_DEPTH = 256,
	parameter int SAMPLE_BITS = 16,
	localparam int ADDR_W = $clog2(HISTORY_DEPTH),
	localparam int WIN_W = $clog2(HISTORY_DEPTH + 1),
	localparam int QW = 1 + ADDR_W + 3 * SAMPLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [WIN_W-1:0]  win,
	mavg3_smp_if.sink         samples,
	input  logic              q_full,
	output logic              q_push,
	output logic [QW-1:0]     q_data
);
	logic [WIN_W-1:0]     fill_q;
	logic [ADDR_W-1:0]    oldest_q;
	logic                 is_prime;
	logic                 wrap;
	logic [ADDR_W-1:0]    slot;
	mavg3_pkg::mavg3_op_t op;

	// Priming until the window is full, then walk the oldest slot round the window.
	assign is_prime = (fill_q < win);
	assign wrap     = ((WIN_W'(oldest_q) + WIN_W'(1)) == win);
	assign slot     = is_prime ? fill_q[ADDR_W-1:0] : oldest_q;
	assign op       = is_prime ? mavg3_pkg::OP_PRIME : mavg3_pkg::OP_STEADY;

	assign samples.ready = !q_full;
	assign q_push        = samples.valid && !q_full;
	assign q_data        = {op, slot, samples.sample_x, samples.sample_y, samples.sample_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (restart) begin
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (q_push) begin
			if (is_prime) begin
				fill_q <= fill_q + WIN_W'(1);
			end else if (wrap) begin
				oldest_q <= '0;
			end else begin
				oldest_q <= oldest_q + ADDR_W'(1);
			end
		end
	end
endmodule

>>> rtl/mavg3_div.sv
module mavg3_div #(
	parameter int HISTORY_DEPTH = 256,
	parameter int SAMPLE_BITS = 16,
	localparam int ADDR_W = $clog2(HISTORY_DEPTH),
	localparam int WIN_W = $clog2(HISTORY_DEPTH + 1),
	localparam int SUM_W = SAMPLE_BITS + ADDR_W + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SUM_W-1:0]       dividend [3],
	input  logic [WIN_W-1:0]              divisor,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] quotient [3]
);
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] mag_q [3];
	logic [WIN_W-1:0] rem_q [3];
	logic             neg_q [3];
	logic [WIN_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIN_W:0]   rem_sh  [3];
	logic             q_bit   [3];
	logic [WIN_W:0]   rem_sub [3];

	// One restoring step per lane per cycle.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rem_sh[a]  = {rem_q[a], mag_q[a][SUM_W-1]};
			q_bit[a]   = (rem_sh[a] >= {1'b0, div_q});
			rem_sub[a] = rem_sh[a] - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int a = 0; a < 3; a++) begin
				neg_q[a] <= dividend[a][SUM_W-1];
				mag_q[a] <= dividend[a][SUM_W-1] ? (SUM_W'(0) - dividend[a]) : dividend[a];
				rem_q[a] <= '0;
			end
		end else if (busy_q) begin
			for (int a = 0; a < 3; a++) begin
				mag_q[a] <= {mag_q[a][SUM_W-2:0], q_bit[a]};
				rem_q[a] <= q_bit[a] ? rem_sub[a][WIN_W-1:0] : rem_sh[a][WIN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(SUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;

	// Quotient magnitude never exceeds the sample range; restore the sign.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			quotient[a] = neg_q[a] ? (SAMPLE_BITS'(0) - mag_q[a][SAMPLE_BITS-1:0])
				: mag_q[a][SAMPLE_BITS-1:0];
		end
	end
endmodule

>>> rtl/mavg3_back.sv
module mavg3_back #(
	parameter int HISTORY_DEPTH = 256,
	parameter int SAMPLE_BITS = 16,
	localparam int ADDR_W = $clog2(HISTORY_DEPTH),
	localparam int WIN_W = $clog2(HISTORY_DEPTH + 1),
	localparam int SUM_W = SAMPLE_BITS + ADDR_W + 1,
	localparam int QW = 1 + ADDR_W + 3 * SAMPLE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [WIN_W-1:0] win,
	input  logic             q_empty,
	input  logic [QW-1:0]    q_data,
	output logic             q_pop,
	mavg3_mean_if.source     means
);
	localparam int S = SAMPLE_BITS;

	mavg3_pkg::mavg3_bk_state_t state_q;
	mavg3_pkg::mavg3_bk_state_t state_d;

	mavg3_pkg::mavg3_op_t op_q;
	logic [ADDR_W-1:0]    slot_q;
	logic [S-1:0]         smp_q [3];
	logic [3*S-1:0]       rd_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [SUM_W-1:0] sum_nxt [3];
	logic                 out_valid_q;
	logic signed [S-1:0]  mean_q [3];

	logic [3*S-1:0]       hist_mem [HISTORY_DEPTH];

	logic [ADDR_W-1:0]    head_slot;
	logic                 mem_we;
	logic                 div_start;
	logic                 out_load;
	logic                 out_free;
	logic                 div_done;
	logic signed [S-1:0]  quot [3];

	assign head_slot = q_data[3*S +: ADDR_W];
	assign out_free  = !out_valid_q || means.ready;

	// Sums after this item: add the new sample, drop the oldest in steady state.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_nxt[a] = sum_q[a] + {{(SUM_W-S){smp_q[a][S-1]}}, smp_q[a]}
				- ((op_q == mavg3_pkg::OP_STEADY)
				? {{(SUM_W-S){rd_q[(2-a)*S+S-1]}}, rd_q[(2-a)*S +: S]}
				: SUM_W'(0));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mavg3_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = mavg3_pkg::BK_UPDATE;
				end
			end
			mavg3_pkg::BK_UPDATE: begin
				state_d = (op_q == mavg3_pkg::OP_STEADY) ? mavg3_pkg::BK_DIV
					: mavg3_pkg::BK_IDLE;
			end
			mavg3_pkg::BK_DIV: begin
				if (div_done && out_free) begin
					state_d = mavg3_pkg::BK_IDLE;
				end
			end
			default: state_d = mavg3_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			mavg3_pkg::BK_IDLE:   q_pop = !q_empty;
			mavg3_pkg::BK_UPDATE: begin
				mem_we    = 1'b1;
				div_start = (op_q == mavg3_pkg::OP_STEADY);
			end
			mavg3_pkg::BK_DIV:    out_load = div_done && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[slot_q] <= {smp_q[0], smp_q[1], smp_q[2]};
		end
		if (q_pop) begin
			rd_q <= hist_mem[head_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= mavg3_pkg::mavg3_op_t'(q_data[QW-1]);
			slot_q <= head_slot;
			for (int a = 0; a < 3; a++) begin
				smp_q[a] <= q_data[(2-a)*S +: S];
			end
		end
		if (out_load) begin
			mean_q <= quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mavg3_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (means.ready) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= '0;
				end
			end else if (mem_we) begin
				sum_q <= sum_nxt;
			end
		end
	end

	mavg3_div #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nxt),
		.divisor  (win),
		.done     (div_done),
		.quotient (quot)
	);

	assign means.valid  = out_valid_q;
	assign means.mean_x = mean_q[0];
	assign means.mean_y = mean_q[1];
	assign means.mean_z = mean_q[2];
endmodule

>>> rtl/moving_average_three_axis.sv
// Three-axis boxcar moving average over signed fixed-point accelerometer samples.
// Each transaction on samples carries one (x, y, z) triple. The first window_length
// transactions after reset or after any write to cfg only fill the history and give
// nothing on means; every later one replaces the oldest sample of each axis and gives
// one transaction on means holding the three window means, each the running sum
// divided by the window and truncated toward zero. A window of zero acts as one and
// a window above HISTORY_DEPTH acts as HISTORY_DEPTH. Write cfg only while the block
// is idle: the write restarts priming and clears the running sums. The history needs
// no clearing pass, so samples are taken straight after reset. In the back end each
// item is fetched with the oldest entry from the history memory, then the sums are
// updated and the memory written, then the bit-serial divider that serves all three
// axes at once runs SAMPLE_BITS + clog2(HISTORY_DEPTH) + 1 steps, and the output
// register is loaded once it is free. Priming items end after the update.
// A two-entry queue sits between the input side and the back end, so samples keep
// being taken while a result waits on means, until the queue is full.
module moving_average_three_axis #(
	parameter int HISTORY_DEPTH = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mavg3_cfg_if.sink    cfg,
	mavg3_smp_if.sink    samples,
	mavg3_mean_if.source means
);
	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int WIN_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int QW     = 1 + ADDR_W + 3 * SAMPLE_BITS;

	logic [mavg3_pkg::WL_BITS-1:0] window_q;
	logic [WIN_W-1:0]              win;
	logic                          restart;

	logic              q_push;
	logic [QW-1:0]     q_push_data;
	logic              q_full;
	logic              q_pop;
	logic [QW-1:0]     q_head;
	logic              q_empty;

	// Register writes are always taken; each one restarts priming.
	assign cfg.ready = 1'b1;
	assign restart   = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= mavg3_pkg::WL_BITS'(1);
		end else if (restart) begin
			window_q <= cfg.window_length;
		end
	end

	// Clamp the programmed window into one to HISTORY_DEPTH.
	always_comb begin
		priority if (window_q == '0) begin
			win = WIN_W'(1);
		end else if (int'(window_q) > HISTORY_DEPTH) begin
			win = WIN_W'(HISTORY_DEPTH);
		end else begin
			win = WIN_W'(window_q);
		end
	end

	// Front end: take samples, decide prime or steady, pick the history slot.
	mavg3_front #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.win     (win),
		.samples (samples),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_push_data)
	);

	// Decouple the two halves so either may stall alone.
	mavg3_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head_data (q_head),
		.empty     (q_empty)
	);

	// Back end: history memory, running sums, divider and output register.
	mavg3_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.win     (win),
		.q_empty (q_empty),
		.q_data  (q_head),
		.q_pop   (q_pop),
		.means   (means)
	);
endmodule

>>> rtl/mavg3_chk.sv
module mavg3_chk #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [mavg3_pkg::WL_BITS-1:0] cfg_data,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_x,
	input logic [SAMPLE_BITS-1:0] out_y,
	input logic [SAMPLE_BITS-1:0] out_z
);
	logic [31:0] pending_q;
	logic        win1_q;
	logic        cfg_acc;
	logic        in_acc;
	logic        out_acc;

	assign cfg_acc = cfg_valid && cfg_ready;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items taken and not yet answered or abandoned by a restart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			win1_q    <= 1'b1;
		end else if (cfg_acc) begin
			pending_q <= '0;
			win1_q    <= (cfg_data <= mavg3_pkg::WL_BITS'(1));
		end else begin
			pending_q <= pending_q + 32'(in_acc) - 32'(out_acc);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 32'd0)
		else $error("result with no item outstanding");

	// Queue, back end, output register and the one priming item.
	a_win1_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win1_q |-> pending_q <= 32'(mavg3_pkg::QUEUE_DEPTH + 3))
		else $error("items held beyond queue and back end with window one");
endmodule

bind moving_average_three_axis mavg3_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_mavg3_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.cfg_data  (cfg.window_length),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (means.valid),
	.out_ready (means.ready),
	.out_x     (means.mean_x),
	.out_y     (means.mean_y),
	.out_z     (means.mean_z)
);

>>> tb/tb.sv
module tb;

	localparam int DEPTH = 256;
	localparam int SBITS = 16;
	// Generous ceiling: roughly 2000 transactions through the bit-serial back end, with stalls.
	localparam int LIMIT_CYCLES = 1000000;
	// Quiet time after the last mean, covering queued priming items.
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic signed [SBITS-1:0] x;
		logic signed [SBITS-1:0] y;
		logic signed [SBITS-1:0] z;
	} mean_triple_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Shadow of the averaging block: own history, running sums and window register.
	class mean_scoreboard;
		logic [mavg3_pkg::WL_BITS-1:0] window_len;
		logic signed [SBITS-1:0] hist [3][DEPTH];
		longint                  sums [3];
		int unsigned             oldest;
		int unsigned             filled;
		mean_triple_t            expected_means [$];
		int                      errors;

		function new();
			errors = 0;
			restart_priming(1);
		endfunction

		function void restart_priming(logic [mavg3_pkg::WL_BITS-1:0] wl);
			window_len = wl;
			for (int a = 0; a < 3; a++)
				sums[a] = 0;
			oldest = 0;
			filled = 0;
		endfunction

		function int unsigned span();
			int unsigned w;
			w = window_len;
			if (w < 1)
				w = 1;
			if (w > DEPTH)
				w = DEPTH;
			return w;
		endfunction

		function int pending();
			return expected_means.size();
		endfunction

		function void note_sample(logic signed [SBITS-1:0] x, logic signed [SBITS-1:0] y,
				logic signed [SBITS-1:0] z);
			logic signed [SBITS-1:0] s [3];
			longint                  q [3];
			int unsigned             w;
			mean_triple_t            m;
			s[0] = x;
			s[1] = y;
			s[2] = z;
			w = span();
			if (filled < w) begin
				for (int a = 0; a < 3; a++) begin
					hist[a][filled] = s[a];
					sums[a] += s[a];
				end
				filled++;
				return;
			end
			for (int a = 0; a < 3; a++) begin
				sums[a] = sums[a] - hist[a][oldest] + s[a];
				hist[a][oldest] = s[a];
				q[a] = sums[a] / longint'(w);
			end
			m.x = q[0][SBITS-1:0];
			m.y = q[1][SBITS-1:0];
			m.z = q[2][SBITS-1:0];
			expected_means.push_back(m);
			oldest = (oldest + 1) % w;
		endfunction

		function void compare_axis(string axis, logic signed [SBITS-1:0] exp_v,
				logic signed [SBITS-1:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: mean_%s mismatch, expected %0d, got %0d", $time, axis, exp_v,
					act_v);
			end
		endfunction

		function void check_mean(logic signed [SBITS-1:0] x, logic signed [SBITS-1:0] y,
				logic signed [SBITS-1:0] z);
			mean_triple_t m;
			if (expected_means.size() == 0) begin
				errors++;
				$display("%0t: unexpected mean transaction, expected none, got (%0d, %0d, %0d)",
					$time, x, y, z);
				return;
			end
			m = expected_means.pop_front();
			compare_axis("x", m.x, x);
			compare_axis("y", m.y, y);
			compare_axis("z", m.z, z);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   gap_pct;
	int   stall_pct;
	int   idle_turn;

	mean_scoreboard sb;

	mavg3_cfg_if                         cfg_bus ();
	mavg3_smp_if  #(.SAMPLE_BITS(SBITS)) sample_bus ();
	mavg3_mean_if #(.SAMPLE_BITS(SBITS)) mean_bus ();

	moving_average_three_axis #(
		.HISTORY_DEPTH(DEPTH),
		.SAMPLE_BITS(SBITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.samples(sample_bus),
		.means(mean_bus)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stall the mean channel at the rate of the current idling phase.
	always @(posedge clk) begin
		mean_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check every mean transaction against the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && mean_bus.valid && mean_bus.ready)
			sb.check_mean(mean_bus.mean_x, mean_bus.mean_y, mean_bus.mean_z);
	end

	function void set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct = 51;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 51;
			end
			default: begin
				gap_pct = 28;
				stall_pct = 28;
			end
		endcase
	endfunction

	// Mostly full-range values, with a share of the rails and of values near zero.
	function logic signed [SBITS-1:0] pick_sample(int extreme_pct);
		if ($urandom_range(99) < extreme_pct)
			return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		if ($urandom_range(3) == 0)
			return 16'($urandom_range(15)) - 16'd8;
		return 16'($urandom);
	endfunction

	// Offer one sample triple, idling first at random, and hold it until taken.
	// Valid stays high afterwards so back-to-back transactions follow without a gap.
	task automatic send_triple(input logic signed [SBITS-1:0] x,
			input logic signed [SBITS-1:0] y, input logic signed [SBITS-1:0] z);
		while ($urandom_range(99) < gap_pct) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid    <= 1'b1;
		sample_bus.sample_x <= x;
		sample_bus.sample_y <= y;
		sample_bus.sample_z <= z;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		sb.note_sample(x, y, z);
	endtask

	// Drop valid, wait for every predicted mean, then let queued priming work finish.
	task automatic settle();
		sample_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window register; the block restarts priming on every write.
	task automatic write_window(input logic [mavg3_pkg::WL_BITS-1:0] wl);
		cfg_bus.valid         <= 1'b1;
		cfg_bus.window_length <= wl;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		sb.restart_priming(wl);
	endtask

	// One setting of the window followed by random traffic; cycle through the idling
	// modes every forty transactions so gaps land on every stage of the back end.
	task automatic run_phase(input logic [mavg3_pkg::WL_BITS-1:0] wl, input int count,
			input int extreme_pct);
		settle();
		write_window(wl);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				set_idling(idle_mode_t'(idle_turn % 4));
				idle_turn++;
			end
			send_triple(pick_sample(extreme_pct), pick_sample(extreme_pct),
				pick_sample(extreme_pct));
		end
	endtask

	initial begin
		sb = new();
		idle_turn = 0;
		set_idling(IDLE_NONE);
		arst_n                <= 1'b0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.window_length <= '0;
		sample_bus.valid      <= 1'b0;
		sample_bus.sample_x   <= '0;
		sample_bus.sample_y   <= '0;
		sample_bus.sample_z   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window of one straight from reset: each mean echoes its sample, rails included.
		send_triple(16'sd0, 16'sd0, 16'sd0);
		send_triple(16'sh7FFF, 16'sh8000, 16'sd0);
		send_triple(16'sh8000, 16'sh7FFF, -16'sd1);
		send_triple(-16'sd1, 16'sd1, -16'sd2);
		send_triple(16'sh5555, 16'shAAAA, 16'sh0F0F);
		send_triple(16'shAAAA, 16'sh5555, 16'shF0F0);

		// Window of zero behaves as a window of one.
		settle();
		write_window(0);
		send_triple(16'sd1, 16'sd2, 16'sd3);
		send_triple(-16'sd5, 16'sd5, 16'sh7FFF);
		send_triple(16'sh8000, 16'sd0, 16'sd1);

		// Window of two: odd negative sums must truncate toward zero, not floor.
		settle();
		write_window(2);
		send_triple(16'sh8000, 16'sh7FFF, -16'sd1);
		send_triple(-16'sd32767, 16'sh7FFF, 16'sd0);
		send_triple(16'sh8000, -16'sd32767, -16'sd3);
		send_triple(16'sh7FFF, 16'sd1, 16'sd3);
		send_triple(16'sh7FFF, 16'sh8000, 16'sh8000);

		// Window of three with mixed signs and remainders.
		settle();
		write_window(3);
		send_triple(16'sd10, -16'sd10, 16'sd1);
		send_triple(16'sd20, -16'sd20, 16'sd1);
		send_triple(16'sd31, -16'sd31, 16'sd0);
		send_triple(16'sd1, -16'sd1, 16'sd1);
		send_triple(-16'sd7, 16'sd7, -16'sd2);
		send_triple(16'sd4, -16'sd4, 16'sd2);

		// Window above the history depth clamps to the depth; rail-heavy samples push
		// the running sums to their limits.
		run_phase(511, 280, 70);
		run_phase(256, 300, 10);
		run_phase(0, 60, 10);
		// Rewrite the window a quarter of the way through priming: the partial fill must be dropped.
		run_phase(200, 50, 10);
		run_phase(3, 120, 10);
		run_phase(2, 120, 20);
		run_phase(5, 120, 10);
		run_phase(7, 120, 10);
		run_phase(16, 100, 30);
		for (int k = 0; k < 3; k++)
			run_phase(mavg3_pkg::WL_BITS'($urandom_range(1, 20)), 80, 15);
		run_phase(255, 280, 10);
		run_phase(1, 50, 10);

		settle();
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/mavg3_pkg.sv
rtl/mavg3_ifs.sv
rtl/mavg3_queue.sv
rtl/mavg3_front.sv
rtl/mavg3_div.sv
rtl/mavg3_back.sv
rtl/moving_average_three_axis.sv
rtl/mavg3_chk.sv
tb/tb.sv
